/* hw/rtl/thsls_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the two-head sigmoid scorer.
// Depends on nothing; every other file of the block uses it.
package thsls_pkg;

   localparam int MaxFeatures = 63;
   localparam int IdxW        = 6;
   localparam int DataW       = 24;
   localparam int SumW        = 48;
   localparam int CntW        = 7;
   localparam int OutW        = 16;
   localparam int ExpW        = 47;
   localparam int YW          = 25;

   localparam logic FuncWeight  = 1'b0;
   localparam logic FuncFeature = 1'b1;

   typedef struct packed {
      logic signed [SumW-1:0] x1;
      logic signed [SumW-1:0] x2;
      logic                   length_error;
   } score_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Clamps an exponent argument to plus or minus 2^23.
   function automatic logic signed [YW-1:0] sat_y(input logic signed [64:0] v);
      if (v > 65'sd8388608) begin
         return 25'sd8388608;
      end else if (v < -65'sd8388608) begin
         return -25'sd8388608;
      end else begin
         return $signed(v[YW-1:0]);
      end
   endfunction

endpackage

/* hw/rtl/thsls_if.sv */
`timescale 1ns / 1ps
// Channel interfaces of the scorer: request items in, score results out.
// Depends on thsls_pkg for field widths.
interface thsls_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   func;
   logic [thsls_pkg::IdxW-1:0]             weight_index;
   logic signed [thsls_pkg::DataW-1:0]     rho_weight;
   logic signed [thsls_pkg::DataW-1:0]     gamma_weight;
   logic signed [thsls_pkg::DataW-1:0]     feature_value;
   logic                                   last;
   modport source(output valid, func, weight_index, rho_weight, gamma_weight,
                  feature_value, last, input ready);
   modport sink(input valid, func, weight_index, rho_weight, gamma_weight,
                feature_value, last, output ready);
endinterface

interface thsls_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [thsls_pkg::OutW-1:0]    rho;
   logic [thsls_pkg::OutW-1:0]    gamma;
   logic                          length_error;
   modport source(output valid, rho, gamma, length_error, input ready);
   modport sink(input valid, rho, gamma, length_error, output ready);
endinterface

/* hw/rtl/thsls_front.sv */
`timescale 1ns / 1ps
// Front end: weight tables and the two multiply-accumulate heads.
// Depends on thsls_pkg and thsls_req_if; feeds finished sums to thsls_queue.
module thsls_front (
   input  logic                              clock,
   input  logic                              reset,
   thsls_req_if.sink                         req_if,
   input  logic [thsls_pkg::IdxW-1:0]        num_features,
   input  thsls_pkg::queue_status_type       q_status,
   output logic                              push,
   output thsls_pkg::score_entry_type        entry
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ADD} state_type;

   state_type state_ff;

   logic signed [thsls_pkg::DataW-1:0] rtab [2**thsls_pkg::IdxW];
   logic signed [thsls_pkg::DataW-1:0] gtab [2**thsls_pkg::IdxW];

   logic signed [thsls_pkg::DataW-1:0] rbias_ff, gbias_ff, rw_ff, gw_ff, feat_ff;
   logic                               last_ff;
   logic signed [2*thsls_pkg::DataW-1:0] rprod_ff, gprod_ff;
   logic signed [thsls_pkg::SumW-1:0]  rsum_ff, gsum_ff, rsum_in, gsum_in;
   logic signed [thsls_pkg::SumW-1:0]  rbase, gbase;
   logic [thsls_pkg::CntW-1:0]         count_ff, count_in;
   logic [thsls_pkg::IdxW-1:0]         slot;
   logic                               accept;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign slot         = count_ff[thsls_pkg::IdxW-1:0] + 6'd1;

   // Weight memory: one write port, registered reads of the bias and the slot.
   always_ff @(posedge clock) begin
      if (accept && req_if.func == thsls_pkg::FuncWeight) begin
         rtab[req_if.weight_index] <= req_if.rho_weight;
         gtab[req_if.weight_index] <= req_if.gamma_weight;
      end
      if (accept) begin
         rbias_ff <= rtab[0];
         gbias_ff <= gtab[0];
         rw_ff    <= rtab[slot];
         gw_ff    <= gtab[slot];
         feat_ff  <= req_if.feature_value;
         last_ff  <= req_if.last;
      end
      rprod_ff <= rw_ff * feat_ff;
      gprod_ff <= gw_ff * feat_ff;
   end

   always_comb begin
      rbase = (count_ff == '0) ? thsls_pkg::SumW'(rbias_ff) : rsum_ff;
      gbase = (count_ff == '0) ? thsls_pkg::SumW'(gbias_ff) : gsum_ff;
      if (count_ff < thsls_pkg::CntW'(thsls_pkg::MaxFeatures)) begin
         rsum_in = rbase + thsls_pkg::SumW'($signed(rprod_ff[47:16]));
         gsum_in = gbase + thsls_pkg::SumW'($signed(gprod_ff[47:16]));
      end else begin
         rsum_in = rbase;
         gsum_in = gbase;
      end
      count_in = (count_ff < thsls_pkg::CntW'(thsls_pkg::MaxFeatures + 1)) ?
                 count_ff + 7'd1 : count_ff;
   end

   assign push               = (state_ff == ST_ADD) && last_ff && !q_status.full;
   assign entry.x1           = rsum_in;
   assign entry.x2           = gsum_in;
   assign entry.length_error = (count_in != {1'b0, num_features});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsum_ff  <= '0;
         gsum_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_if.func == thsls_pkg::FuncFeature) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               if (!last_ff) begin
                  rsum_ff  <= rsum_in;
                  gsum_ff  <= gsum_in;
                  count_ff <= count_in;
                  state_ff <= ST_IDLE;
               end else if (!q_status.full) begin
                  rsum_ff  <= rsum_in;
                  gsum_ff  <= gsum_in;
                  count_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* hw/rtl/thsls_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of finished sums between the front end and the back end.
// Depends on thsls_pkg.
module thsls_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  thsls_pkg::score_entry_type    push_entry,
   input  logic                          pop,
   output thsls_pkg::score_entry_type    pop_entry,
   output thsls_pkg::queue_status_type   status
);

   thsls_pkg::score_entry_type slots_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign pop_entry    = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

/* hw/rtl/thsls_back.sv */
`timescale 1ns / 1ps
// Back end: shared fixed-point exponential, Gompertz scaling and the
// reciprocal divider for the logistic head. Depends on thsls_pkg and thsls_rsp_if.
module thsls_back (
   input  logic                              clock,
   input  logic                              reset,
   input  thsls_pkg::score_entry_type        entry,
   input  thsls_pkg::queue_status_type       q_status,
   output logic                              pop,
   input  logic signed [15:0]                rho_shift,
   thsls_rsp_if.source                       rsp_if
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXP_T, ST_EXP_A, ST_EXP_B, ST_EXP_C, ST_EXP_SH, ST_Z_MUL, ST_DIV, ST_FIN
   } state_type;
   typedef enum logic [1:0] {PH_RHO_IN, PH_RHO_OUT, PH_GAMMA} phase_type;

   state_type state_ff;
   phase_type phase_ff;

   logic signed [thsls_pkg::YW-1:0]    y_ff;
   logic signed [26:0]                 t_ff;
   logic [16:0]                        acc_ff;
   logic [thsls_pkg::ExpW-1:0]         exp_ff;
   logic signed [thsls_pkg::SumW-1:0]  x2_ff;
   logic                               err_ff;
   logic [thsls_pkg::OutW-1:0]         rho_res_ff;
   logic [65:0]                        rem_ff;
   logic [47:0]                        div_d_ff;
   logic [16:0]                        quot_ff;
   logic [4:0]                         step_ff;
   logic                               out_valid_ff;
   logic [thsls_pkg::OutW-1:0]         out_rho_ff, out_gamma_ff;
   logic                               out_err_ff;

   logic signed [42:0]                 t_prod;
   logic [15:0]                        frac;
   logic [16:0]                        coef;
   logic [32:0]                        poly_prod;
   logic [17:0]                        p_val;
   logic signed [10:0]                 n_val, neg_n;
   logic [thsls_pkg::ExpW-1:0]         exp_val;
   logic signed [63:0]                 z_prod;
   logic [47:0]                        d_val;
   logic [65:0]                        trial;

   assign t_prod    = y_ff * 18'sd94548;
   assign frac      = t_ff[15:0];
   assign poly_prod = frac * coef;
   assign p_val     = 18'd65536 + {1'b0, acc_ff};
   assign n_val     = t_ff[26:16];
   assign neg_n     = -n_val;
   assign z_prod    = rho_shift * $signed({1'b0, exp_ff});
   assign d_val     = 48'd65536 + {1'b0, exp_val};
   assign trial     = 66'(div_d_ff) << step_ff;

   always_comb begin
      unique case (state_ff)
         ST_EXP_A: coef = 17'd5152;
         ST_EXP_B: coef = 17'd14823 + acc_ff;
         default:  coef = 17'd45561 + acc_ff;
      endcase
   end

   // Scale the polynomial mantissa by the integer power of two.
   always_comb begin
      if (n_val > 11'sd30) begin
         exp_val = {thsls_pkg::ExpW{1'b1}};
      end else if (n_val >= 11'sd0) begin
         exp_val = thsls_pkg::ExpW'(p_val) << n_val[4:0];
      end else if (neg_n >= 11'sd40) begin
         exp_val = '0;
      end else begin
         exp_val = thsls_pkg::ExpW'(p_val) >> neg_n[5:0];
      end
   end

   assign pop                 = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.rho          = out_rho_ff;
   assign rsp_if.gamma        = out_gamma_ff;
   assign rsp_if.length_error = out_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_RHO_IN;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FIN && (!out_valid_ff || rsp_if.ready)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  y_ff     <= thsls_pkg::sat_y(-(65'($signed(entry.x1))));
                  x2_ff    <= entry.x2;
                  err_ff   <= entry.length_error;
                  phase_ff <= PH_RHO_IN;
                  state_ff <= ST_EXP_T;
               end
            end
            ST_EXP_T: begin
               t_ff     <= t_prod[42:16];
               state_ff <= ST_EXP_A;
            end
            ST_EXP_A: begin
               acc_ff   <= poly_prod[32:16];
               state_ff <= ST_EXP_B;
            end
            ST_EXP_B: begin
               acc_ff   <= poly_prod[32:16];
               state_ff <= ST_EXP_C;
            end
            ST_EXP_C: begin
               acc_ff   <= poly_prod[32:16];
               state_ff <= ST_EXP_SH;
            end
            ST_EXP_SH: begin
               unique case (phase_ff)
                  PH_RHO_IN: begin
                     exp_ff   <= exp_val;
                     state_ff <= ST_Z_MUL;
                  end
                  PH_RHO_OUT: begin
                     rho_res_ff <= (exp_val > 47'd65535) ? 16'hFFFF : exp_val[15:0];
                     y_ff       <= thsls_pkg::sat_y(-(65'($signed(x2_ff))));
                     phase_ff   <= PH_GAMMA;
                     state_ff   <= ST_EXP_T;
                  end
                  default: begin
                     div_d_ff <= d_val;
                     rem_ff   <= 66'(64'h1_0000_0000) + 66'(d_val >> 1);
                     quot_ff  <= '0;
                     step_ff  <= 5'd16;
                     state_ff <= ST_DIV;
                  end
               endcase
            end
            ST_Z_MUL: begin
               y_ff     <= thsls_pkg::sat_y($signed({{9{z_prod[63]}}, z_prod[63:8]}));
               phase_ff <= PH_RHO_OUT;
               state_ff <= ST_EXP_T;
            end
            ST_DIV: begin
               if (rem_ff >= trial) begin
                  rem_ff           <= rem_ff - trial;
                  quot_ff[step_ff] <= 1'b1;
               end
               if (step_ff == 5'd0) begin
                  state_ff <= ST_FIN;
               end else begin
                  step_ff <= step_ff - 5'd1;
               end
            end
            ST_FIN: begin
               if (!out_valid_ff || rsp_if.ready) begin
                  out_rho_ff   <= rho_res_ff;
                  out_gamma_ff <= quot_ff[16] ? 16'hFFFF : quot_ff[15:0];
                  out_err_ff   <= err_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* hw/rtl/two_head_sigmoid_linear_scorer.sv */
`timescale 1ns / 1ps
// Two-head linear scorer with Gompertz and logistic outputs. Weight transactions
// (func 0) write a bias pair at slot 0 and per-feature weight pairs at slot i+1;
// the tables must be written before use. A weight transaction leaves the front
// end idle. Each feature transaction passes through three front-end steps
// (weight read, multiply, accumulate), and the input side takes no new
// element until the accumulate step is done. On the element marked last the
// two sums enter a two-entry queue and the back end evaluates the sigmoids:
// the shared exponential unit runs three times through its steps T, A, B, C
// and shift, plus one scaling multiply, a restoring divider, an output step
// and the step that takes the vector from the queue. The back end works on
// one vector while the front end accumulates the next. A finished result
// waits in an output register; while it is not taken the back end holds the
// next result in its last step, and once the queue is full the front end
// stalls on the element marked last.
// Configuration registers num_features (address 0) and rho_shift (address 4); the
// user writes them over the csr_ port only while the block is idle (not enforced).
// Depends on thsls_pkg, thsls_if, thsls_front, thsls_queue and thsls_back.
module two_head_sigmoid_linear_scorer (
   input  logic         clock,
   input  logic         reset,
   thsls_req_if.sink    req_if,
   thsls_rsp_if.source  rsp_if,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic CsrNumFeatures = 1'b0;
   localparam logic CsrRhoShift    = 1'b1;

   logic [thsls_pkg::IdxW-1:0]  num_features_ff;
   logic signed [15:0]          rho_shift_ff;
   logic                        csr_write;
   logic                        csr_index;

   thsls_pkg::score_entry_type  push_entry, pop_entry;
   thsls_pkg::queue_status_type q_status;
   logic                        q_push, q_pop;

   // Register file: pready is always high, a write lands in the access phase.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_index)
         CsrNumFeatures: csr_prdata = {26'b0, num_features_ff};
         default:        csr_prdata = {{16{rho_shift_ff[15]}}, rho_shift_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_features_ff <= 6'd1;
         rho_shift_ff    <= -16'sd768;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrNumFeatures: num_features_ff <= csr_pwdata[5:0];
            CsrRhoShift:    rho_shift_ff    <= $signed(csr_pwdata[15:0]);
         endcase
      end
   end

   thsls_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .num_features (num_features_ff),
      .q_status     (q_status),
      .push         (q_push),
      .entry        (push_entry)
   );

   thsls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   thsls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .entry     (pop_entry),
      .q_status  (q_status),
      .pop       (q_pop),
      .rho_shift (rho_shift_ff),
      .rsp_if    (rsp_if)
   );

   // The front end must never push a finished vector into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("push into full queue");

   // The back end must never take a vector from an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid after reset");

endmodule

/* sim/tb_two_head_sigmoid_linear_scorer.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the two-head sigmoid linear scorer.
// Depends on thsls_pkg, the thsls_if channel interfaces and the scorer RTL.
module tb_two_head_sigmoid_linear_scorer;

   localparam longint ExpCap     = (64'sd1 <<< 47) - 1;
   localparam int     CycleLimit = 900000;
   localparam logic [2:0] AddrNumFeatures = 3'd0;
   localparam logic [2:0] AddrRhoShift    = 3'd4;

   // The scoreboard keeps its own copy of the weight tables, the sums and the
   // configuration, and predicts one score per vector.
   class score_board;
      typedef struct {
         logic [thsls_pkg::OutW-1:0] rho;
         logic [thsls_pkg::OutW-1:0] gamma;
         logic                       length_error;
      } score_type;

      logic signed [thsls_pkg::DataW-1:0] rho_table[0:thsls_pkg::MaxFeatures];
      logic signed [thsls_pkg::DataW-1:0] gamma_table[0:thsls_pkg::MaxFeatures];
      logic signed [thsls_pkg::SumW-1:0]  rho_acc;
      logic signed [thsls_pkg::SumW-1:0]  gamma_acc;
      int unsigned             count;
      int unsigned             num_features;
      logic signed [15:0]      rho_shift;
      score_type               pending_scores[$];
      int                      errors;
      int                      scores_checked;

      function new();
         rho_acc = '0;
         gamma_acc = '0;
         count = 0;
         num_features = 1;
         rho_shift = -16'sd768;
         errors = 0;
         scores_checked = 0;
      endfunction

      // Q16 exponential: base-two split with a cubic for the fraction.
      function longint exp_q16(longint y);
         longint t, n, f, p;
         if (y > 64'sd8388608) y = 64'sd8388608;
         if (y < -64'sd8388608) y = -64'sd8388608;
         t = (y * 64'sd94548) >>> 16;
         n = t >>> 16;
         f = t - n * 64'sd65536;
         p = 65536 + ((f * (45561 + ((f * (14823 + ((f * 5152) >>> 16))) >>> 16))) >>> 16);
         if (n > 30) return ExpCap;
         if (n >= 0) begin
            p = p <<< n;
            return (p > ExpCap) ? ExpCap : p;
         end
         if (-n >= 40) return 0;
         return p >>> (-n);
      endfunction

      function void note_input(logic func, logic [thsls_pkg::IdxW-1:0] idx,
                               logic signed [thsls_pkg::DataW-1:0] rw,
                               logic signed [thsls_pkg::DataW-1:0] gw,
                               logic signed [thsls_pkg::DataW-1:0] fv,
                               logic last);
         longint    tr, tg, x1, x2, z, r, d, g;
         score_type s;
         if (func == thsls_pkg::FuncWeight) begin
            rho_table[idx] = rw;
            gamma_table[idx] = gw;
            return;
         end
         if (count == 0) begin
            rho_acc = thsls_pkg::SumW'(longint'(rho_table[0]));
            gamma_acc = thsls_pkg::SumW'(longint'(gamma_table[0]));
         end
         // Elements past the table depth add nothing; the count saturates at MaxFeatures + 1.
         if (count < thsls_pkg::MaxFeatures) begin
            tr = (longint'(rho_table[count + 1]) * longint'(fv)) >>> 16;
            tg = (longint'(gamma_table[count + 1]) * longint'(fv)) >>> 16;
            rho_acc = rho_acc + thsls_pkg::SumW'(tr);
            gamma_acc = gamma_acc + thsls_pkg::SumW'(tg);
         end
         if (count < thsls_pkg::MaxFeatures + 1) count++;
         if (!last) return;
         x1 = longint'(rho_acc);
         x2 = longint'(gamma_acc);
         z = (longint'(rho_shift) * exp_q16(-x1)) >>> 8;
         r = exp_q16(z);
         if (r > 65535) r = 65535;
         d = 65536 + exp_q16(-x2);
         g = ((64'sd1 <<< 32) + (d >>> 1)) / d;
         if (g > 65535) g = 65535;
         s.rho = r[thsls_pkg::OutW-1:0];
         s.gamma = g[thsls_pkg::OutW-1:0];
         s.length_error = (count != num_features);
         pending_scores = {pending_scores, s};
         count = 0;
      endfunction

      task report(string what, longint got, longint want);
         errors++;
         if (errors <= 40) $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      endtask

      task check_result(logic [thsls_pkg::OutW-1:0] rho, logic [thsls_pkg::OutW-1:0] gamma,
                        logic length_error);
         score_type s;
         if (pending_scores.size() == 0) begin
            report("unexpected score transaction, rho", rho, -1);
            return;
         end
         s = pending_scores.pop_front();
         scores_checked++;
         if (rho !== s.rho) report("rho", rho, s.rho);
         if (gamma !== s.gamma) report("gamma", gamma, s.gamma);
         if (length_error !== s.length_error) report("length_error", length_error,
                                                     s.length_error);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   thsls_req_if req_if();
   thsls_rsp_if rsp_if();

   score_board scores = new();
   int  cycles = 0;
   int  items_sent = 0;
   int  vectors_sent = 0;
   int  config_writes = 0;
   bit  quiet = 1'b0;
   int  rsp_stall = 0;

   two_head_sigmoid_linear_scorer dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.func = thsls_pkg::FuncWeight;
      req_if.weight_index = '0;
      req_if.rho_weight = '0;
      req_if.gamma_weight = '0;
      req_if.feature_value = '0;
      req_if.last = 1'b0;
      rsp_if.ready = 1'b0;
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("two_head_sigmoid_linear_scorer regression: fail");
         $finish;
      end
   end

   // Result side: every score transaction is checked against the oldest
   // prediction. Signals are sampled right after the edge, so they hold the
   // values that the edge itself saw. Ready stalls are mostly short, a few long.
   always @(posedge clock) begin
      logic next_ready;
      if (!reset && rsp_if.valid && rsp_if.ready)
         scores.check_result(rsp_if.rho, rsp_if.gamma, rsp_if.length_error);
      if (reset) begin
         next_ready = 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         next_ready = 1'b0;
      end else begin
         next_ready = 1'b1;
         if (!quiet && $urandom_range(0, 99) < 25)
            rsp_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 3);
      end
      rsp_if.ready <= next_ready;
   end

   // Idle gap after an input transaction: usually none or short, sometimes long.
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drives one input transaction and waits for it to be accepted. Valid stays
   // high into the next transaction when no gap follows.
   task automatic send(logic func, logic [thsls_pkg::IdxW-1:0] idx,
                       logic [thsls_pkg::DataW-1:0] rw, logic [thsls_pkg::DataW-1:0] gw,
                       logic [thsls_pkg::DataW-1:0] fv, logic last);
      int gap;
      req_if.valid <= 1'b1;
      req_if.func <= func;
      req_if.weight_index <= idx;
      req_if.rho_weight <= rw;
      req_if.gamma_weight <= gw;
      req_if.feature_value <= fv;
      req_if.last <= last;
      do @(posedge clock); while (!req_if.ready);
      scores.note_input(func, idx, rw, gw, fv, last);
      items_sent++;
      if (func == thsls_pkg::FuncFeature && last) vectors_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random 24-bit value: moderate most of the time so the sigmoids land in
   // their interesting range, otherwise full range, an extreme or zero.
   function automatic logic [thsls_pkg::DataW-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return thsls_pkg::DataW'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
      if (r < 85) return thsls_pkg::DataW'($urandom());
      if (r < 90) return 24'h7FFFFF;
      if (r < 95) return 24'h800000;
      return '0;
   endfunction

   // Lowers valid and lets the block drain so that registers can be written.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (scores.pending_scores.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      config_writes++;
   endtask

   task automatic csr_read_check(logic [2:0] addr, int width, logic [31:0] want);
      logic [31:0] mask;
      mask = (32'd1 << width) - 1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & mask) !== (want & mask))
         scores.report("register readback", csr_prdata & mask, want & mask);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(int unsigned nf, logic signed [15:0] shift);
      wait_idle();
      csr_write(AddrNumFeatures, 32'(nf));
      csr_write(AddrRhoShift, 32'(unsigned'(shift)));
      csr_read_check(AddrNumFeatures, 6, 32'(nf));
      csr_read_check(AddrRhoShift, 16, 32'(unsigned'(shift)));
      scores.num_features = nf;
      scores.rho_shift = shift;
   endtask

   // One feature vector of the given length; weight reloads may land between
   // elements, which the block must honor immediately.
   task automatic send_vector(int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 4)
            send(thsls_pkg::FuncWeight,
                 thsls_pkg::IdxW'($urandom_range(0, thsls_pkg::MaxFeatures)), pick_value(),
                 pick_value(), thsls_pkg::DataW'($urandom()), 1'($urandom()));
         send(thsls_pkg::FuncFeature, thsls_pkg::IdxW'($urandom()),
              thsls_pkg::DataW'($urandom()), thsls_pkg::DataW'($urandom()),
              pick_value(), (i == len - 1));
      end
   endtask

   initial begin
      int unsigned nf_list[7];
      logic signed [15:0] shift_list[7];
      int budget;
      int len;
      int r;
      nf_list = '{1, 63, 0, 8, 3, 40, 17};
      shift_list = '{-16'sd768, 16'sh7FFF, -16'sh8000, 16'sd0, -16'sd256,
                     16'sd512, -16'sd3000};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every slot is written before any feature reads it.
      quiet = 1'b1;
      for (int k = 0; k <= thsls_pkg::MaxFeatures; k++)
         send(thsls_pkg::FuncWeight, thsls_pkg::IdxW'(k), pick_value(), pick_value(),
              thsls_pkg::DataW'($urandom()), 1'($urandom()));
      quiet = 1'b0;

      // Directed: extreme weights against extreme features, a bias-only
      // style vector, and a vector that runs past the table depth.
      send(thsls_pkg::FuncWeight, 6'd0, 24'h7FFFFF, 24'h800000, 24'h000000, 1'b0);
      send(thsls_pkg::FuncWeight, 6'd1, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 1'b1);
      send(thsls_pkg::FuncFeature, 6'd0, '0, '0, 24'h7FFFFF, 1'b1);
      send(thsls_pkg::FuncFeature, 6'd63, '1, '1, 24'h800000, 1'b1);
      send(thsls_pkg::FuncWeight, 6'd0, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 1'b0);
      send(thsls_pkg::FuncWeight, 6'd1, 24'h800000, 24'h800000, 24'h000000, 1'b0);
      send(thsls_pkg::FuncFeature, 6'd0, '0, '0, 24'h800000, 1'b1);
      send(thsls_pkg::FuncFeature, 6'd0, '0, '0, 24'h000000, 1'b1);
      send(thsls_pkg::FuncWeight, 6'd0, 24'h000000, 24'h000000, 24'h0, 1'b0);
      send(thsls_pkg::FuncWeight, 6'd1, 24'h010000, 24'hFF0000, 24'h0, 1'b0);
      send(thsls_pkg::FuncFeature, 6'd0, '0, '0, 24'h010000, 1'b1);
      send_vector(2);
      send_vector(thsls_pkg::MaxFeatures + 3);

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < 7; ph++) begin
         configure(nf_list[ph], (ph == 6) ? 16'($urandom()) : shift_list[ph]);
         quiet = (ph == 3);
         budget = items_sent + 130;
         while (items_sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) len = (nf_list[ph] == 0) ? $urandom_range(1, 4) : nf_list[ph];
            else if (r < 90) len = $urandom_range(1, 12);
            else if (r < 96)
               len = $urandom_range(thsls_pkg::MaxFeatures, thsls_pkg::MaxFeatures + 3);
            else len = $urandom_range(1, thsls_pkg::MaxFeatures);
            send_vector(len);
         end
         quiet = 1'b0;
      end

      // Drain outstanding scores, then allow the back end to settle.
      req_if.valid <= 1'b0;
      while (scores.pending_scores.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Covered %0d input transactions in %0d vectors, %0d scores checked,",
               items_sent, vectors_sent, scores.scores_checked);
      $display("%0d register writes across seven settings, %0d mismatches.",
               config_writes, scores.errors);
      if (scores.errors == 0 && scores.pending_scores.size() == 0) begin
         $display("two_head_sigmoid_linear_scorer regression: pass");
      end else begin
         $display("two_head_sigmoid_linear_scorer regression: fail");
      end
      $finish;
   end

endmodule
